// ----- hw/rtl/usr_pkg.sv -----
package usr_pkg;

  // register slots on the configuration port
  localparam logic [2:0] REG_TIMEOUT    = 3'd0;
  localparam logic [2:0] REG_TRIGGER    = 3'd1;
  localparam logic [2:0] REG_POST_DELAY = 3'd2;
  localparam logic [2:0] REG_COUNT      = 3'd3;
  localparam logic [2:0] REG_POLARITY   = 3'd4;

  // register values after reset
  localparam logic [31:0] TIMEOUT_RESET    = 32'd2400000;
  localparam logic [15:0] TRIGGER_RESET    = 16'd480;
  localparam logic [31:0] POST_DELAY_RESET = 32'd192000;
  localparam logic [3:0]  COUNT_RESET      = 4'd8;
  localparam logic        POLARITY_RESET   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_NORMAL      = 2'd0;
  localparam logic [1:0] ST_NO_RESPONSE = 2'd1;
  localparam logic [1:0] ST_UNFINISHED  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_LISTEN,
    PH_POST
  } phase_t;

  typedef enum logic [1:0] {
    EC_IDLE,
    EC_WAIT_RISE,
    EC_WAIT_FALL
  } echo_t;

  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic [15:0] trigger_ticks;
    logic [31:0] post_delay_ticks;
    logic [3:0]  sensor_count;
    logic        echo_active_high;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic        trigger_on;
    logic [2:0]  trigger_sensor;
    logic        busy_res;
    logic        result_valid;
    logic [2:0]  result_sensor;
    logic [1:0]  result_status;
    logic [31:0] echo_width;
    logic        round_done;
  } out_t;

endpackage

// ----- hw/rtl/usr_cfg.sv -----
module usr_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output usr_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks    <= usr_pkg::TIMEOUT_RESET;
      cfg.trigger_ticks    <= usr_pkg::TRIGGER_RESET;
      cfg.post_delay_ticks <= usr_pkg::POST_DELAY_RESET;
      cfg.sensor_count     <= usr_pkg::COUNT_RESET;
      cfg.echo_active_high <= usr_pkg::POLARITY_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        usr_pkg::REG_TIMEOUT:    cfg.timeout_ticks    <= pwdata;
        usr_pkg::REG_TRIGGER:    cfg.trigger_ticks    <= pwdata[15:0];
        usr_pkg::REG_POST_DELAY: cfg.post_delay_ticks <= pwdata;
        usr_pkg::REG_COUNT:      cfg.sensor_count     <= pwdata[3:0];
        usr_pkg::REG_POLARITY:   cfg.echo_active_high <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      usr_pkg::REG_TIMEOUT:    prdata = cfg.timeout_ticks;
      usr_pkg::REG_TRIGGER:    prdata = {16'd0, cfg.trigger_ticks};
      usr_pkg::REG_POST_DELAY: prdata = cfg.post_delay_ticks;
      usr_pkg::REG_COUNT:      prdata = {28'd0, cfg.sensor_count};
      usr_pkg::REG_POLARITY:   prdata = {31'd0, cfg.echo_active_high};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/usr_engine.sv -----
module usr_engine #(
  parameter int MAX_SENSOR_COUNT = 8,
  parameter int TICK_WIDTH       = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  usr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  usr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output usr_pkg::out_t out_data
);

  localparam int SIDX_W = (MAX_SENSOR_COUNT > 1) ? $clog2(MAX_SENSOR_COUNT) : 1;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX   = '1;
  localparam logic [31:0]           TICK_MAX32 = 32'(TICK_MAX);
  localparam logic [4:0]            COUNT_MAX  = 5'(MAX_SENSOR_COUNT);
  localparam logic [SIDX_W-1:0]     LAST_MAX   = SIDX_W'(MAX_SENSOR_COUNT - 1);

  // input stage
  logic          hold_valid;
  usr_pkg::in_t  hold_data;
  logic          step;

  // ranging state
  usr_pkg::phase_t        phase, phase_next;
  usr_pkg::echo_t         echo_phase, echo_phase_next;
  logic [SIDX_W-1:0]      sensor_index, sensor_index_next;
  logic [TICK_WIDTH-1:0]  phase_ticks, phase_ticks_next;
  logic [TICK_WIDTH-1:0]  rise_time, rise_time_next;

  // derived limits
  logic [31:0]       trig_lim;
  logic [31:0]       timeout_lim;
  logic [31:0]       post_lim;
  logic [SIDX_W-1:0] last_index;
  logic              active;
  logic              finished;
  usr_pkg::out_t     result;

  assign step     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_data <= in_data;
    end
  end

  // limits with zero taken as one; timeout and post delay clipped to the tick counter range
  always_comb begin
    trig_lim = (cfg.trigger_ticks == 16'd0) ? 32'd1 : 32'(cfg.trigger_ticks);

    if (cfg.timeout_ticks > TICK_MAX32) begin
      timeout_lim = TICK_MAX32;
    end else if (cfg.timeout_ticks == 32'd0) begin
      timeout_lim = 32'd1;
    end else begin
      timeout_lim = cfg.timeout_ticks;
    end

    if (cfg.post_delay_ticks > TICK_MAX32) begin
      post_lim = TICK_MAX32;
    end else if (cfg.post_delay_ticks == 32'd0) begin
      post_lim = 32'd1;
    end else begin
      post_lim = cfg.post_delay_ticks;
    end

    if (cfg.sensor_count == 4'd0) begin
      last_index = '0;
    end else if ({1'b0, cfg.sensor_count} > COUNT_MAX) begin
      last_index = LAST_MAX;
    end else begin
      last_index = SIDX_W'(cfg.sensor_count - 4'd1);
    end
  end

  assign active = (hold_data.echo_level == cfg.echo_active_high);

  // one tick of the ranging sequencer
  always_comb begin
    phase_next        = phase;
    echo_phase_next   = echo_phase;
    sensor_index_next = sensor_index;
    phase_ticks_next  = phase_ticks;
    rise_time_next    = rise_time;
    finished          = 1'b0;
    result            = '0;

    if (phase == usr_pkg::PH_IDLE && hold_data.start_req) begin
      phase_next        = usr_pkg::PH_TRIG;
      sensor_index_next = '0;
      phase_ticks_next  = '0;
      echo_phase_next   = usr_pkg::EC_IDLE;
    end

    if (phase_next != usr_pkg::PH_IDLE) begin
      result.trigger_sensor = 3'(sensor_index_next);
    end

    case (phase_next)
      usr_pkg::PH_IDLE: ;
      usr_pkg::PH_TRIG: begin
        result.trigger_on = 1'b1;
        if (phase_ticks_next != TICK_MAX) begin
          phase_ticks_next = phase_ticks_next + TICK_WIDTH'(1);
        end
        if (32'(phase_ticks_next) >= trig_lim) begin
          phase_next       = usr_pkg::PH_LISTEN;
          phase_ticks_next = '0;
          echo_phase_next  = usr_pkg::EC_WAIT_RISE;
        end
      end
      usr_pkg::PH_LISTEN: begin
        // echo edges first, then the timeout
        if (echo_phase_next == usr_pkg::EC_WAIT_RISE) begin
          if (active) begin
            echo_phase_next = usr_pkg::EC_WAIT_FALL;
            rise_time_next  = phase_ticks_next;
          end
        end else if (echo_phase_next == usr_pkg::EC_WAIT_FALL) begin
          if (!active) begin
            result.echo_width    = 32'(phase_ticks_next - rise_time_next);
            result.result_status = usr_pkg::ST_NORMAL;
            finished             = 1'b1;
          end
        end
        if (!finished && 32'(phase_ticks_next) >= timeout_lim) begin
          result.result_status = (echo_phase_next == usr_pkg::EC_WAIT_FALL) ?
                                 usr_pkg::ST_UNFINISHED : usr_pkg::ST_NO_RESPONSE;
          result.echo_width    = 32'd0;
          finished             = 1'b1;
        end
        if (finished) begin
          result.result_valid  = 1'b1;
          result.result_sensor = 3'(sensor_index_next);
          echo_phase_next      = usr_pkg::EC_IDLE;
          phase_next           = usr_pkg::PH_POST;
          phase_ticks_next     = (cfg.post_delay_ticks == 32'd0) ? TICK_MAX : '0;
        end else if (phase_ticks_next != TICK_MAX) begin
          phase_ticks_next = phase_ticks_next + TICK_WIDTH'(1);
        end
      end
      usr_pkg::PH_POST: begin
        if ((phase_ticks_next != TICK_MAX || cfg.post_delay_ticks != 32'd0) &&
            phase_ticks_next != TICK_MAX) begin
          phase_ticks_next = phase_ticks_next + TICK_WIDTH'(1);
        end
        if (cfg.post_delay_ticks == 32'd0 || 32'(phase_ticks_next) >= post_lim) begin
          phase_ticks_next = '0;
          echo_phase_next  = usr_pkg::EC_IDLE;
          // a count lowered during a round ends it at the next sensor change
          if (sensor_index_next >= last_index) begin
            sensor_index_next = '0;
            phase_next        = usr_pkg::PH_IDLE;
            result.round_done = 1'b1;
          end else begin
            sensor_index_next = sensor_index_next + SIDX_W'(1);
            phase_next        = usr_pkg::PH_TRIG;
          end
        end
      end
      default: phase_next = usr_pkg::PH_IDLE;
    endcase

    result.busy_res = (phase_next != usr_pkg::PH_IDLE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= usr_pkg::PH_IDLE;
      echo_phase   <= usr_pkg::EC_IDLE;
      sensor_index <= '0;
      phase_ticks  <= '0;
      rise_time    <= '0;
    end else if (step) begin
      phase        <= phase_next;
      echo_phase   <= echo_phase_next;
      sensor_index <= sensor_index_next;
      phase_ticks  <= phase_ticks_next;
      rise_time    <= rise_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

// ----- hw/rtl/ultrasonic_multi_sensor_ranging.sv -----
// channel   direction  handshake            payload
// in        input      in_valid / in_ready    in_data  (usr_pkg::in_t, one timer tick)
// out       output     out_valid / out_ready  out_data (usr_pkg::out_t, one per tick)
// cfg       input      APB psel / penable     paddr, pwdata, prdata
//
// one tick is taken every cycle while the output does not stall; its result passes the
// input register, then the result register, set by the single-pass sequencer step
// synchronous reset clears the sequencer and loads register defaults
// a stalled result register holds its transfer and the input register keeps one
// more tick, so in_ready drops only while both are full and out_ready is low
module ultrasonic_multi_sensor_ranging #(
  parameter int MAX_SENSOR_COUNT = 8,
  parameter int TICK_WIDTH       = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  usr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output usr_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  usr_pkg::cfg_t cfg;

  // configuration registers
  usr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // tick sequencer
  usr_engine #(
    .MAX_SENSOR_COUNT (MAX_SENSOR_COUNT),
    .TICK_WIDTH       (TICK_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // a finished sensor leaves the round running in its post delay
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_valid |-> out_data.busy_res)
    else $error("result reported outside a running round");

  // the end of a round leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.round_done |-> !out_data.busy_res && !out_data.result_valid)
    else $error("round end with block still busy or result present");

  // a width is only carried by a normal result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.echo_width != 32'd0 |->
      out_data.result_valid && out_data.result_status == usr_pkg::ST_NORMAL)
    else $error("pulse width without a normal result");

  // a trigger tick is never the tick that ends the round
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trigger_on |-> out_data.busy_res && !out_data.round_done)
    else $error("trigger driven outside a running round");
`endif

endmodule
